### hw/rtl/mcfd_pkg.sv
package mcfd_pkg;

    // Frame framing
    localparam int unsigned FRAME_LIMIT = 80;
    localparam int unsigned POS_W       = $clog2(FRAME_LIMIT);

    // Kept character positions within a frame
    localparam int unsigned KEEP_N = 7;
    localparam int unsigned KEEP_POS [KEEP_N] = '{1, 3, 5, 7, 9, 13, 17};

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned SPEED_W = 10;
    localparam int unsigned CFG_IDX_W = 2;

    // Characters
    localparam logic [CHAR_W-1:0] CH_START = 8'h24;  // '$'
    localparam logic [CHAR_W-1:0] CH_END   = 8'h23;  // '#'
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_1     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_2     = 8'h32;
    localparam logic [CHAR_W-1:0] CH_4     = 8'h34;
    localparam logic [CHAR_W-1:0] CH_8     = 8'h38;
    localparam logic [CHAR_W-1:0] CH_W     = 8'h57;
    localparam logic [CHAR_W-1:0] CH_D     = 8'h44;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_CEILING = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_FLOOR   = 2'd2;

    localparam logic [SPEED_W-1:0] RST_SPEED_STEP    = 10'd100;
    localparam logic [SPEED_W-1:0] RST_SPEED_CEILING = 10'd1000;
    localparam logic [SPEED_W-1:0] RST_SPEED_FLOOR   = 10'd100;
    localparam logic [SPEED_W-1:0] RST_SPEED         = 10'd500;

    // Tag matcher progress
    localparam logic [1:0] TAG_IDLE = 2'd0;
    localparam logic [1:0] TAG_GOT4 = 2'd1;
    localparam logic [1:0] TAG_GOTW = 2'd2;

    // Motion codes
    localparam logic [2:0] MOT_HALT        = 3'd0;
    localparam logic [2:0] MOT_PIVOT_LEFT  = 3'd5;
    localparam logic [2:0] MOT_PIVOT_RIGHT = 3'd6;

    // Execution markers
    localparam logic [2:0] EXEC_S       = 3'd4;
    localparam logic [2:0] EXEC_Q       = 3'd5;
    localparam logic [2:0] EXEC_E       = 3'd6;
    localparam logic [2:0] EXEC_UNKNOWN = 3'd7;

    localparam logic [3:0] LIGHT_NONE = 4'd0;

    localparam logic [1:0] SERVO_NONE = 2'd0;
    localparam logic [1:0] SERVO_180  = 2'd1;
    localparam logic [1:0] SERVO_0    = 2'd2;
    localparam logic [1:0] SERVO_90   = 2'd3;

    typedef logic [CHAR_W-1:0] t_chars [KEEP_N];

    // Last member sits in the lowest bits
    typedef struct packed {
        logic [1:0]         servo_action;
        logic [3:0]         light_action;
        logic               beep;
        logic [2:0]         exec_code;
        logic [SPEED_W-1:0] speed;
        logic [2:0]         motion;
    } t_result;

    typedef struct packed {
        logic [SPEED_W-1:0] speed_step;
        logic [SPEED_W-1:0] speed_ceiling;
        logic [SPEED_W-1:0] speed_floor;
    } t_cfg;

endpackage

### hw/rtl/mcfd_decode.sv
module mcfd_decode (
    input  mcfd_pkg::t_chars                    i_chars,
    input  logic [mcfd_pkg::SPEED_W-1:0]        i_speed,
    input  mcfd_pkg::t_cfg                      i_cfg,
    output mcfd_pkg::t_result                   o_result
);

    logic [mcfd_pkg::CHAR_W-1:0]  w_c1, w_c3, w_c5, w_c7, w_c9, w_c13, w_c17;
    logic [mcfd_pkg::SPEED_W:0]   w_sum;
    logic signed [mcfd_pkg::SPEED_W+1:0] w_diff;

    assign w_c1  = i_chars[0];
    assign w_c3  = i_chars[1];
    assign w_c5  = i_chars[2];
    assign w_c7  = i_chars[3];
    assign w_c9  = i_chars[4];
    assign w_c13 = i_chars[5];
    assign w_c17 = i_chars[6];

    assign w_sum  = {1'b0, i_speed} + {1'b0, i_cfg.speed_step};
    assign w_diff = $signed({2'b00, i_speed}) - $signed({2'b00, i_cfg.speed_step});

    always_comb begin
        // motion and marker; spin wins over position 1
        if (w_c3 == mcfd_pkg::CH_1) begin
            o_result.motion    = mcfd_pkg::MOT_PIVOT_LEFT;
            o_result.exec_code = mcfd_pkg::EXEC_Q;
        end else if (w_c3 == mcfd_pkg::CH_2) begin
            o_result.motion    = mcfd_pkg::MOT_PIVOT_RIGHT;
            o_result.exec_code = mcfd_pkg::EXEC_E;
        end else if (w_c1 >= mcfd_pkg::CH_1 && w_c1 <= mcfd_pkg::CH_4) begin
            o_result.motion    = 3'(w_c1 - mcfd_pkg::CH_0);
            o_result.exec_code = 3'(w_c1 - mcfd_pkg::CH_1);
        end else begin
            o_result.motion    = mcfd_pkg::MOT_HALT;
            o_result.exec_code = (w_c1 == mcfd_pkg::CH_0) ? mcfd_pkg::EXEC_S
                                                          : mcfd_pkg::EXEC_UNKNOWN;
        end

        // saturating speed step
        if (w_c7 == mcfd_pkg::CH_1) begin
            o_result.speed = (w_sum > {1'b0, i_cfg.speed_ceiling}) ? i_cfg.speed_ceiling
                                                                  : w_sum[mcfd_pkg::SPEED_W-1:0];
        end else if (w_c7 == mcfd_pkg::CH_2) begin
            o_result.speed = (w_diff < $signed({2'b00, i_cfg.speed_floor}))
                           ? i_cfg.speed_floor : w_diff[mcfd_pkg::SPEED_W-1:0];
        end else begin
            o_result.speed = i_speed;
        end

        o_result.beep = (w_c5 == mcfd_pkg::CH_1);

        if (w_c13 >= mcfd_pkg::CH_1 && w_c13 <= mcfd_pkg::CH_8) begin
            o_result.light_action = 4'(w_c13 - mcfd_pkg::CH_0);
        end else begin
            o_result.light_action = mcfd_pkg::LIGHT_NONE;
        end

        // position 17 overrides position 9
        if (w_c17 == mcfd_pkg::CH_1) begin
            o_result.servo_action = mcfd_pkg::SERVO_90;
        end else if (w_c9 == mcfd_pkg::CH_1) begin
            o_result.servo_action = mcfd_pkg::SERVO_180;
        end else if (w_c9 == mcfd_pkg::CH_2) begin
            o_result.servo_action = mcfd_pkg::SERVO_0;
        end else begin
            o_result.servo_action = mcfd_pkg::SERVO_NONE;
        end
    end

endmodule

### hw/rtl/motor_command_frame_decoder.sv
// Motor command frame decoder.
// Input: a byte stream on s_axis (one received serial byte per transaction).
// '$' opens or reopens a frame, '#' closes it. A frame reaching 80 bytes
// ('$' included) is dropped. A closed frame not carrying the "4WD" tag
// (looked for up to the first zero byte) yields one result transaction on
// m_axis: motion, stepped speed, execution marker, beep, light and servo.
// Configuration: i_cfg_we writes speed step, ceiling or floor (index 0..2);
// write only while no frame result is outstanding.
// Latency: the result for a '#' appears on m_axis the cycle after the '#'
// transaction. Throughput: one byte per cycle; all per-byte work is a few
// compares and one saturating add/subtract ahead of the result register.
// Stall: the result register holds while m_axis_tready is low, and
// s_axis_tready then drops, so nothing is lost or reordered.
// Reset (synchronous, active low): no frame open, speed 500, registers at
// step 100, ceiling 1000, floor 100, output empty.
module motor_command_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    // byte input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    // frame results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [2:0] motion, [12:3] speed, [15:13] exec_code,
                                        // [16] beep, [20:17] light_action,
                                        // [22:21] servo_action, [23] zero
);

    localparam logic [mcfd_pkg::POS_W-1:0] POS_LAST =
        mcfd_pkg::POS_W'(mcfd_pkg::FRAME_LIMIT - 1);

    // frame state
    logic                          r_in_frame, n_in_frame;
    logic [mcfd_pkg::POS_W-1:0]    r_pos, n_pos;
    mcfd_pkg::t_chars              r_chars, n_chars;
    logic [1:0]                    r_match, n_match;
    logic                          r_tag, n_tag;
    logic                          r_zero, n_zero;
    logic [mcfd_pkg::SPEED_W-1:0]  r_speed;
    mcfd_pkg::t_cfg                r_cfg;

    // output stage
    logic                          r_out_valid;
    mcfd_pkg::t_result             r_result;

    // per-byte view (after a possible '$' restart)
    logic                          w_acc;
    logic                          w_start, w_active, w_over, w_end, w_emit;
    logic [mcfd_pkg::POS_W-1:0]    w_pos;
    mcfd_pkg::t_chars              w_chars;
    logic [1:0]                    w_match;
    logic                          w_tag, w_zero;
    logic [mcfd_pkg::CHAR_W-1:0]   w_byte;
    mcfd_pkg::t_result             w_result;

    assign w_byte   = s_axis_tdata;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_acc    = s_axis_tvalid && s_axis_tready;

    assign w_start  = (w_byte == mcfd_pkg::CH_START);
    assign w_active = w_start || r_in_frame;
    assign w_pos    = w_start ? '0 : r_pos;
    assign w_match  = w_start ? mcfd_pkg::TAG_IDLE : r_match;
    assign w_tag    = w_start ? 1'b0 : r_tag;
    assign w_zero   = w_start ? 1'b0 : r_zero;
    assign w_over   = (w_pos >= POS_LAST);
    assign w_end    = (w_byte == mcfd_pkg::CH_END);

    always_comb begin
        for (int k = 0; k < mcfd_pkg::KEEP_N; k++) begin
            w_chars[k] = w_start ? '0 : r_chars[k];
        end
    end

    // next frame state
    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_chars    = r_chars;
        n_match    = r_match;
        n_tag      = r_tag;
        n_zero     = r_zero;
        if (w_active) begin
            if (w_over) begin
                // overlong frame: drop it
                n_in_frame = 1'b0;
                n_pos      = '0;
                n_match    = mcfd_pkg::TAG_IDLE;
                n_tag      = 1'b0;
                n_zero     = 1'b0;
                for (int k = 0; k < mcfd_pkg::KEEP_N; k++) begin
                    n_chars[k] = '0;
                end
            end else begin
                for (int k = 0; k < mcfd_pkg::KEEP_N; k++) begin
                    n_chars[k] = (w_pos == mcfd_pkg::POS_W'(mcfd_pkg::KEEP_POS[k]))
                               ? w_byte : w_chars[k];
                end
                n_tag  = w_tag;
                n_zero = w_zero;
                n_match = w_match;
                // tag search stops at the first zero byte
                if (!w_zero) begin
                    priority if (w_byte == mcfd_pkg::CH_NUL) begin
                        n_zero  = 1'b1;
                        n_match = mcfd_pkg::TAG_IDLE;
                    end else if (w_byte == mcfd_pkg::CH_4) begin
                        n_match = mcfd_pkg::TAG_GOT4;
                    end else if (w_match == mcfd_pkg::TAG_GOT4 && w_byte == mcfd_pkg::CH_W) begin
                        n_match = mcfd_pkg::TAG_GOTW;
                    end else if (w_match == mcfd_pkg::TAG_GOTW && w_byte == mcfd_pkg::CH_D) begin
                        n_tag   = 1'b1;
                        n_match = mcfd_pkg::TAG_IDLE;
                    end else begin
                        n_match = mcfd_pkg::TAG_IDLE;
                    end
                end
                if (w_end) begin
                    n_in_frame = 1'b0;
                    n_pos      = '0;
                end else begin
                    n_in_frame = 1'b1;
                    n_pos      = w_pos + 1'b1;
                end
            end
        end
    end

    assign w_emit = w_active && !w_over && w_end && !n_tag;

    mcfd_decode u_decode (
        .i_chars  (n_chars),
        .i_speed  (r_speed),
        .i_cfg    (r_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_match    <= mcfd_pkg::TAG_IDLE;
            r_tag      <= 1'b0;
            r_zero     <= 1'b0;
            r_speed    <= mcfd_pkg::RST_SPEED;
            r_out_valid <= 1'b0;
            for (int k = 0; k < mcfd_pkg::KEEP_N; k++) begin
                r_chars[k] <= '0;
            end
        end else begin
            if (w_acc) begin
                r_in_frame <= n_in_frame;
                r_pos      <= n_pos;
                r_chars    <= n_chars;
                r_match    <= n_match;
                r_tag      <= n_tag;
                r_zero     <= n_zero;
                if (w_emit) begin
                    r_speed <= w_result.speed;
                end
            end
            r_out_valid <= (w_acc && w_emit) || (r_out_valid && !m_axis_tready);
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge i_clk) begin
        if (w_acc && w_emit) begin
            r_result <= w_result;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_step    <= mcfd_pkg::RST_SPEED_STEP;
            r_cfg.speed_ceiling <= mcfd_pkg::RST_SPEED_CEILING;
            r_cfg.speed_floor   <= mcfd_pkg::RST_SPEED_FLOOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mcfd_pkg::REG_SPEED_STEP:    r_cfg.speed_step    <= i_cfg_data;
                mcfd_pkg::REG_SPEED_CEILING: r_cfg.speed_ceiling <= i_cfg_data;
                mcfd_pkg::REG_SPEED_FLOOR:   r_cfg.speed_floor   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_result};

    // checks
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("frame position beyond limit");

    a_idle_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> r_pos == '0)
        else $error("position not cleared outside a frame");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result stalled");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_emit) |=> m_axis_tvalid)
        else $error("frame result not presented");

    a_motion_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_result.motion <= mcfd_pkg::MOT_PIVOT_RIGHT)
        else $error("motion code out of range");

endmodule
